// ===== rtl/tick_periodic_task_scheduler_macros.svh =====
// Assertion macros for the scheduler top level.
`ifndef TICK_PERIODIC_TASK_SCHEDULER_MACROS_SVH
`define TICK_PERIODIC_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tps_pkg.sv =====
// Shared constants and types for the tick periodic task scheduler.
package tps_pkg;

    localparam int NUM_TASKS = 8;

    localparam int MODE_W      = 2;
    localparam int PERIOD_W    = 16;
    localparam int COUNT_W     = 16;
    localparam int SUB_SEC_W   = 10;
    localparam int SUB_MIN_W   = 6;
    localparam int SLOT_IDX_W  = 3;
    localparam int MASK_W      = 8;
    localparam int PEND_EXT_W  = NUM_TASKS + MASK_W;

    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COLLECT = 2'd2;

    localparam logic [SUB_SEC_W-1:0] MS_LAST  = 10'd999;
    localparam logic [SUB_MIN_W-1:0] SEC_LAST = 6'd59;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the input word
        logic exec;     // apply the latched word and load the result register
    } t_dp_cmd;

endpackage

// ===== rtl/tick_periodic_task_scheduler.sv =====
// Top level of the tick periodic task scheduler: controller, datapath and checks.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_ready  | i_mode, i_period
//  out     | from block| o_out_valid / i_out_ready| o_millis, o_seconds, o_minutes,
//          |           |                          | o_slot_index, o_create_failed,
//          |           |                          | o_pending_mask
//
// Each word is handled in two steps: one latches it, one applies it to the counters and
// the slot table and loads the result register. The controller's two-state loop sets
// this order, so the block takes no new word until the last one has been applied.
// The result register parts the channels: a new word is taken while a result waits,
// and that word holds in the apply state until the result register is free.
// Synchronous active-low reset clears the counters, slot occupancy and pending bits;
// countdown and period entries stay undefined until a create writes them.
module tick_periodic_task_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [tps_pkg::MODE_W-1:0]        i_mode,
    input  logic [tps_pkg::PERIOD_W-1:0]      i_period,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tps_pkg::COUNT_W-1:0]       o_millis,
    output logic [tps_pkg::COUNT_W-1:0]       o_seconds,
    output logic [tps_pkg::COUNT_W-1:0]       o_minutes,
    output logic [tps_pkg::SLOT_IDX_W-1:0]    o_slot_index,
    output logic                              o_create_failed,
    output logic [tps_pkg::MASK_W-1:0]        o_pending_mask
);
    import tps_pkg::*;

    `include "tick_periodic_task_scheduler_macros.svh"

    t_dp_cmd cmd;

    // Sequence each word: latch it, then apply it once the result register is free.
    tps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Hold the time base and the slot table, and build the result word.
    tps_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (i_mode),
        .i_period        (i_period),
        .o_millis        (o_millis),
        .o_seconds       (o_seconds),
        .o_minutes       (o_minutes),
        .o_slot_index    (o_slot_index),
        .o_create_failed (o_create_failed),
        .o_pending_mask  (o_pending_mask)
    );

    // A failed create must report slot zero.
    `TPS_ASSERT_NOW(a_fail_slot_zero, i_clk, i_rst_n, o_out_valid && o_create_failed, o_slot_index == '0, "create failure with nonzero slot index")

    // After a word is taken the block is busy applying it and takes no other.
    `TPS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken while previous word still in flight")

    // Latch and apply never happen together.
    `TPS_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, cmd.exec, !cmd.capture, "latch and apply issued in the same cycle")

endmodule

// ===== rtl/tps_ctrl.sv =====
// Handshake controller for the tick periodic task scheduler.
module tps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tps_pkg::t_dp_cmd o_cmd
);
    import tps_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold the item until the result register can take the word
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/tps_dp.sv =====
// Time base counters, task slot table and result register.
module tps_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tps_pkg::t_dp_cmd                  i_cmd,
    input  logic [tps_pkg::MODE_W-1:0]        i_mode,
    input  logic [tps_pkg::PERIOD_W-1:0]      i_period,
    output logic [tps_pkg::COUNT_W-1:0]       o_millis,
    output logic [tps_pkg::COUNT_W-1:0]       o_seconds,
    output logic [tps_pkg::COUNT_W-1:0]       o_minutes,
    output logic [tps_pkg::SLOT_IDX_W-1:0]    o_slot_index,
    output logic                              o_create_failed,
    output logic [tps_pkg::MASK_W-1:0]        o_pending_mask
);
    import tps_pkg::*;

    // latched item
    logic [MODE_W-1:0]   r_mode;
    logic [PERIOD_W-1:0] r_period;

    // time base
    logic [COUNT_W-1:0]   r_millis_count,  n_millis_count;
    logic [COUNT_W-1:0]   r_seconds_count, n_seconds_count;
    logic [COUNT_W-1:0]   r_minutes_count, n_minutes_count;
    logic [SUB_SEC_W-1:0] r_sub_second,    n_sub_second;
    logic [SUB_MIN_W-1:0] r_sub_minute,    n_sub_minute;

    // slot table
    logic [NUM_TASKS-1:0] r_slot_used,    n_slot_used;
    logic [NUM_TASKS-1:0] r_slot_pending, n_slot_pending;
    logic [PERIOD_W-1:0]  r_slot_countdown [NUM_TASKS];
    logic [PERIOD_W-1:0]  n_slot_countdown [NUM_TASKS];
    logic [PERIOD_W-1:0]  r_slot_period    [NUM_TASKS];
    logic [PERIOD_W-1:0]  n_slot_period    [NUM_TASKS];

    // result register
    logic [COUNT_W-1:0]    r_millis, r_seconds, r_minutes;
    logic [SLOT_IDX_W-1:0] r_slot_index,   n_slot_index;
    logic                  r_create_failed, n_create_failed;
    logic [MASK_W-1:0]     r_pending_mask,  n_pending_mask;

    logic [NUM_TASKS-1:0]  claim;
    logic                  found;
    logic [PERIOD_W-1:0]   cd_dec;
    logic [PEND_EXT_W-1:0] pend_before;
    logic [PEND_EXT_W-1:0] pend_after;

    // lowest free slot, one-hot
    always_comb begin
        claim        = '0;
        found        = 1'b0;
        n_slot_index = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (!r_slot_used[i] && !found) begin
                claim[i]     = 1'b1;
                found        = 1'b1;
                n_slot_index = SLOT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_millis_count   = r_millis_count;
        n_seconds_count  = r_seconds_count;
        n_minutes_count  = r_minutes_count;
        n_sub_second     = r_sub_second;
        n_sub_minute     = r_sub_minute;
        n_slot_used      = r_slot_used;
        n_slot_pending   = r_slot_pending;
        n_slot_countdown = r_slot_countdown;
        n_slot_period    = r_slot_period;
        n_create_failed  = 1'b0;
        cd_dec           = '0;
        case (r_mode)
            MODE_TICK: begin
                n_millis_count = r_millis_count + 1'b1;
                if (r_sub_second == MS_LAST) begin
                    n_sub_second    = '0;
                    n_seconds_count = r_seconds_count + 1'b1;
                    if (r_sub_minute == SEC_LAST) begin
                        n_sub_minute    = '0;
                        n_minutes_count = r_minutes_count + 1'b1;
                    end else begin
                        n_sub_minute = r_sub_minute + 1'b1;
                    end
                end else begin
                    n_sub_second = r_sub_second + 1'b1;
                end
                for (int i = 0; i < NUM_TASKS; i++) begin
                    cd_dec = (r_slot_countdown[i] != '0) ? r_slot_countdown[i] - 1'b1
                                                         : r_slot_countdown[i];
                    if (r_slot_used[i]) begin
                        if (cd_dec == '0) begin
                            n_slot_pending[i]   = 1'b1;
                            n_slot_countdown[i] = r_slot_period[i];
                        end else begin
                            n_slot_countdown[i] = cd_dec;
                        end
                    end
                end
            end
            MODE_CREATE: begin
                n_create_failed = !found;
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (claim[i]) begin
                        n_slot_used[i]      = 1'b1;
                        n_slot_pending[i]   = 1'b0;
                        n_slot_countdown[i] = '0;
                        n_slot_period[i]    = r_period;
                    end
                end
            end
            MODE_COLLECT: begin
                n_slot_pending = '0;
            end
            default: begin
            end
        endcase
    end

    assign pend_before = PEND_EXT_W'(r_slot_pending);
    assign pend_after  = PEND_EXT_W'(n_slot_pending);

    always_comb begin
        if (r_mode == MODE_COLLECT) begin
            n_pending_mask = pend_before[MASK_W-1:0];
        end else begin
            n_pending_mask = pend_after[MASK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_millis_count  <= '0;
            r_seconds_count <= '0;
            r_minutes_count <= '0;
            r_sub_second    <= '0;
            r_sub_minute    <= '0;
            r_slot_used     <= '0;
            r_slot_pending  <= '0;
        end else if (i_cmd.exec) begin
            r_millis_count  <= n_millis_count;
            r_seconds_count <= n_seconds_count;
            r_minutes_count <= n_minutes_count;
            r_sub_second    <= n_sub_second;
            r_sub_minute    <= n_sub_minute;
            r_slot_used     <= n_slot_used;
            r_slot_pending  <= n_slot_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_period <= i_period;
        end
        if (i_cmd.exec) begin
            r_slot_countdown <= n_slot_countdown;
            r_slot_period    <= n_slot_period;
            r_millis         <= n_millis_count;
            r_seconds        <= n_seconds_count;
            r_minutes        <= n_minutes_count;
            r_slot_index     <= (r_mode == MODE_CREATE && found) ? n_slot_index : '0;
            r_create_failed  <= n_create_failed;
            r_pending_mask   <= n_pending_mask;
        end
    end

    assign o_millis        = r_millis;
    assign o_seconds       = r_seconds;
    assign o_minutes       = r_minutes;
    assign o_slot_index    = r_slot_index;
    assign o_create_failed = r_create_failed;
    assign o_pending_mask  = r_pending_mask;

endmodule
